### rtl/hffsw_pkg.sv
// Shared constants for the HLL shallow-water face flux unit.
package hffsw_pkg;

  localparam int unsigned FIELD_W = 32;   // width of every stream field
  localparam int unsigned N_IN    = 7;    // input fields per transfer
  localparam int unsigned GRAV_W  = 21;   // gravity register width
  localparam int unsigned FRAC_W  = 16;   // Q16.16 fraction bits

  localparam logic [GRAV_W-1:0] GRAV_RESET = 21'd642908;
  localparam logic [23:0]       C_G981     = 24'd642908;  // 9.81 in Q16.16
  localparam logic [1:0]        C_DMIN     = 2'd3;        // minimum depth, raw

  // Square root: 24 result bits, four per pipeline stage.
  localparam int unsigned SQ_BITS = 24;
  localparam int unsigned SQ_PER  = 4;
  localparam int unsigned SQ_ST   = SQ_BITS / SQ_PER;
  localparam int unsigned SQ_W    = 48;

  // Divider: four quotient bits per pipeline stage.
  localparam int unsigned DIV_PER = 4;

endpackage

### rtl/hll_face_flux_shallow_water_unit.sv
// HLL face flux unit: streaming pipeline from face inputs to pressure-term flux.
//
// Takes one cell face per cycle unless a stalled output has filled the pipeline,
// and returns its HLL flux (Q16.16, saturated to 32 bits).
// The wave celerities come from the two-rarefaction root pipeline (six stages,
// four result bits each) and the blend from the restoring divider (four quotient
// bits per stage); every stage holds its own valid bit, so bubbles close up under
// output stall and the input keeps accepting while a result waits, until every
// stage is full. The gravity register may be rewritten only while the pipeline
// is empty.
module hll_face_flux_shallow_water_unit
  import hffsw_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // eta_left, eta_right, bed_level, depth_here, depth_next, vel_left, vel_right
  input  logic [N_IN*FIELD_W-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // face_flux
  output logic [FIELD_W-1:0]        m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [GRAV_W-1:0]         cfg_data_i
);

  localparam int W      = DATA_WIDTH;
  localparam int XW     = 2 * W + 2;
  localparam int DIV_ST = (W + FRAC_W + DIV_PER - 1) / DIV_PER;
  localparam int DN     = DIV_ST * DIV_PER;

  localparam int ST_S1  = 0;
  localparam int ST_S2  = 1;
  localparam int ST_S3  = 2;
  localparam int ST_RT  = 3;
  localparam int ST_US  = ST_RT + SQ_ST;
  localparam int ST_SLR = ST_US + 1;
  localparam int ST_PRD = ST_SLR + 1;
  localparam int ST_PR2 = ST_PRD + 1;
  localparam int ST_NUM = ST_PR2 + 1;
  localparam int ST_DV  = ST_NUM + 1;
  localparam int ST_OUT = ST_DV + DIV_ST;
  localparam int NS     = ST_OUT + 1;

  typedef struct packed {
    logic signed [W-1:0] ul;
    logic signed [W-1:0] ur;
    logic signed [W-1:0] uh;  // floor of mean velocity
    logic signed [W-1:0] qd;  // floor((ul-ur)/4)
    logic signed [W-1:0] dv;  // ur - ul
  } cy_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
    if (x[XW-1:W-1] == '0 || x[XW-1:W-1] == '1) return x[W-1:0];
    return x[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat_w(XW'(a) + XW'(b));
  endfunction

  function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat_w(XW'(a) - XW'(b));
  endfunction

  // floor(a*b / 2^sh), saturated
  function automatic logic signed [W-1:0] mulsh(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b,
                                                input int sh);
    logic signed [2*W-1:0] p;
    p = a * b;
    return sat_w(XW'(p >>> sh));
  endfunction

  function automatic logic signed [W-1:0] fld(input logic [FIELD_W-1:0] v);
    return sat_w(XW'(signed'(v)));
  endfunction

  function automatic logic [SQ_W-1:0] rt_arg(input logic signed [W-1:0] arg);
    logic [63:0] ae;
    ae = 64'(unsigned'(arg));
    if (arg[W-1]) return '0;
    if (|ae[63:31]) return {1'b0, {31{1'b1}}, 16'h0};
    return {1'b0, ae[30:0], 16'h0};
  endfunction

  function automatic logic [FIELD_W-1:0] sat32(input logic signed [W-1:0] v);
    logic signed [64:0] e;
    e = 65'(v);
    if (e[64:31] == '0 || e[64:31] == '1) return e[31:0];
    return e[64] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // ---------------------------------------------------------------- control
  logic [GRAV_W-1:0] gravity_q;
  logic [NS-1:0]     v_q;
  logic [NS-1:0]     ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAV_RESET;
    end else if (cfg_valid_i) begin
      gravity_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    ld[NS-1] = ~v_q[NS-1] | m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = ~v_q[k] | ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = v_q[ST_OUT];

  logic signed [W-1:0] grav_s, g981_s, dmin_s;
  assign grav_s = $signed(W'(gravity_q));
  assign g981_s = $signed(W'(C_G981));
  assign dmin_s = $signed(W'(C_DMIN));

  // ---------------------------------------------------------------- stage 1
  logic signed [W-1:0] in_el, in_er, in_bed, in_dh, in_dn, in_ul, in_ur;
  logic signed [W-1:0] sql_q, ebl_q, sqrr_q, ebr_q, el_q, er_q, hm_q;
  cy_t                 cy1_q;

  assign in_el  = fld(s_axis_tdata[0*FIELD_W +: FIELD_W]);
  assign in_er  = fld(s_axis_tdata[1*FIELD_W +: FIELD_W]);
  assign in_bed = fld(s_axis_tdata[2*FIELD_W +: FIELD_W]);
  assign in_dh  = fld(s_axis_tdata[3*FIELD_W +: FIELD_W]);
  assign in_dn  = fld(s_axis_tdata[4*FIELD_W +: FIELD_W]);
  assign in_ul  = fld(s_axis_tdata[5*FIELD_W +: FIELD_W]);
  assign in_ur  = fld(s_axis_tdata[6*FIELD_W +: FIELD_W]);

  always_ff @(posedge clk_i) begin
    if (ld[ST_S1]) begin
      sql_q    <= mulsh(in_el, in_el, FRAC_W);
      ebl_q    <= mulsh(in_el, in_bed, FRAC_W);
      sqrr_q   <= mulsh(in_er, in_er, FRAC_W);
      ebr_q    <= mulsh(in_er, in_bed, FRAC_W);
      el_q     <= in_el;
      er_q     <= in_er;
      hm_q     <= qadd(in_dh, in_dn) >>> 1;
      cy1_q.ul <= in_ul;
      cy1_q.ur <= in_ur;
      cy1_q.uh <= qadd(in_ul, in_ur) >>> 1;
      cy1_q.qd <= qsub(in_ul, in_ur) >>> 2;
      cy1_q.dv <= qsub(in_ur, in_ul);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [W-1:0] dlt, drt;
  logic signed [W-1:0] dl2_q, dr2_q, dfl_q, dfr_q;
  cy_t                 cy2_q;

  assign dlt = qadd(el_q, hm_q);
  assign drt = qadd(er_q, hm_q);

  always_ff @(posedge clk_i) begin
    if (ld[ST_S2]) begin
      dl2_q <= (dlt < dmin_s) ? dmin_s : dlt;
      dr2_q <= (drt < dmin_s) ? dmin_s : drt;
      dfl_q <= qsub(sql_q, qadd(ebl_q, ebl_q));
      dfr_q <= qsub(sqrr_q, qadd(ebr_q, ebr_q));
      cy2_q <= cy1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [W-1:0] argl_q, argr_q, fl3_q, fr3_q;
  cy_t                 cy3_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_S3]) begin
      argl_q <= mulsh(dl2_q, g981_s, FRAC_W);
      argr_q <= mulsh(dr2_q, g981_s, FRAC_W);
      fl3_q  <= mulsh(dfl_q, grav_s, FRAC_W + 1);
      fr3_q  <= mulsh(dfr_q, grav_s, FRAC_W + 1);
      cy3_q  <= cy2_q;
    end
  end

  // ---------------------------------------------------------------- root pipeline
  // remainder form: rem = n - res^2, one result bit per step
  logic [SQ_W-1:0]    rt_rem_q [SQ_ST][2];
  logic [SQ_BITS-1:0] rt_res_q [SQ_ST][2];
  logic signed [W-1:0] rt_fl_q [SQ_ST];
  logic signed [W-1:0] rt_fr_q [SQ_ST];
  cy_t                 rt_cy_q [SQ_ST];

  for (genvar g = 0; g < SQ_ST; g++) begin : g_rt
    logic [SQ_W-1:0]     rem_in [2];
    logic [SQ_BITS-1:0]  res_in [2];
    logic [SQ_W-1:0]     rem_nx [2];
    logic [SQ_BITS-1:0]  res_nx [2];
    logic signed [W-1:0] fl_in, fr_in;
    cy_t                 cy_in;

    if (g == 0) begin : g_first
      assign rem_in[0] = rt_arg(argl_q);
      assign rem_in[1] = rt_arg(argr_q);
      assign res_in[0] = '0;
      assign res_in[1] = '0;
      assign fl_in     = fl3_q;
      assign fr_in     = fr3_q;
      assign cy_in     = cy3_q;
    end else begin : g_next
      assign rem_in[0] = rt_rem_q[g-1][0];
      assign rem_in[1] = rt_rem_q[g-1][1];
      assign res_in[0] = rt_res_q[g-1][0];
      assign res_in[1] = rt_res_q[g-1][1];
      assign fl_in     = rt_fl_q[g-1];
      assign fr_in     = rt_fr_q[g-1];
      assign cy_in     = rt_cy_q[g-1];
    end

    always_comb begin
      logic [SQ_W-1:0]    r;
      logic [SQ_BITS-1:0] s;
      logic [SQ_W-1:0]    t;
      int                 bi;
      for (int sd = 0; sd < 2; sd++) begin
        r = rem_in[sd];
        s = res_in[sd];
        for (int j = 0; j < SQ_PER; j++) begin
          bi = SQ_BITS - 1 - (g * SQ_PER + j);
          t  = (SQ_W'(s) << (bi + 1)) + (SQ_W'(1) << (2 * bi));
          if (r >= t) begin
            r = r - t;
            s = s | (SQ_BITS'(1) << bi);
          end
        end
        rem_nx[sd] = r;
        res_nx[sd] = s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[ST_RT+g]) begin
        rt_rem_q[g][0] <= rem_nx[0];
        rt_rem_q[g][1] <= rem_nx[1];
        rt_res_q[g][0] <= res_nx[0];
        rt_res_q[g][1] <= res_nx[1];
        rt_fl_q[g]     <= fl_in;
        rt_fr_q[g]     <= fr_in;
        rt_cy_q[g]     <= cy_in;
      end
    end
  end

  // ---------------------------------------------------------------- star state
  logic signed [W-1:0] cl, cr;
  logic signed [W-1:0] cl_q, cr_q, us_q, cs_q, fl4_q, fr4_q;
  cy_t                 cy4_q;

  assign cl = sat_w(XW'(rt_res_q[SQ_ST-1][0]));
  assign cr = sat_w(XW'(rt_res_q[SQ_ST-1][1]));

  always_ff @(posedge clk_i) begin
    if (ld[ST_US]) begin
      cl_q  <= cl;
      cr_q  <= cr;
      us_q  <= qsub(qadd(rt_cy_q[SQ_ST-1].uh, cl), cr);
      cs_q  <= qadd(qadd(cl, cr) >>> 1, rt_cy_q[SQ_ST-1].qd);
      fl4_q <= rt_fl_q[SQ_ST-1];
      fr4_q <= rt_fr_q[SQ_ST-1];
      cy4_q <= rt_cy_q[SQ_ST-1];
    end
  end

  // ---------------------------------------------------------------- wave speeds
  logic signed [W-1:0] t1, t2, t3, t4;
  logic signed [W-1:0] sl5_q, sr5_q, fl5_q, fr5_q, dv5_q;

  assign t1 = qsub(cy4_q.ul, cl_q);
  assign t2 = qsub(us_q, cs_q);
  assign t3 = qadd(cy4_q.ur, cr_q);
  assign t4 = qadd(us_q, cs_q);

  always_ff @(posedge clk_i) begin
    if (ld[ST_SLR]) begin
      sl5_q <= (t2 < t1) ? t2 : t1;
      sr5_q <= (t4 > t3) ? t4 : t3;
      fl5_q <= fl4_q;
      fr5_q <= fr4_q;
      dv5_q <= cy4_q.dv;
    end
  end

  // ---------------------------------------------------------------- products
  logic signed [W-1:0] pa_q, pb_q, pp_q, dv6_q, sl6_q, sr6_q, up6_q;
  logic                bl6_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_PRD]) begin
      pa_q  <= mulsh(sr5_q, fl5_q, FRAC_W);
      pb_q  <= mulsh(sl5_q, fr5_q, FRAC_W);
      pp_q  <= mulsh(sr5_q, sl5_q, FRAC_W);
      dv6_q <= dv5_q;
      sl6_q <= sl5_q;
      sr6_q <= sr5_q;
      bl6_q <= sl5_q[W-1] && !sr5_q[W-1] && (|sr5_q);
      up6_q <= sl5_q[W-1] ? fr5_q : fl5_q;
    end
  end

  logic signed [W-1:0] ab_q, pc_q, sl7_q, sr7_q, up7_q;
  logic                bl7_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_PR2]) begin
      ab_q  <= qsub(pa_q, pb_q);
      pc_q  <= mulsh(pp_q, dv6_q, FRAC_W);
      sl7_q <= sl6_q;
      sr7_q <= sr6_q;
      bl7_q <= bl6_q;
      up7_q <= up6_q;
    end
  end

  // ---------------------------------------------------------------- numerator
  logic signed [W-1:0] num;
  logic [W:0]          num_mag;
  logic [DN-1:0]       nm_x_q;
  logic [W-1:0]        nm_d_q;
  logic signed [W-1:0] nm_up_q;
  logic                nm_neg_q, nm_bl_q;

  assign num     = qadd(ab_q, pc_q);
  assign num_mag = num[W-1] ? -((W+1)'(num)) : (W+1)'(num);

  always_ff @(posedge clk_i) begin
    if (ld[ST_NUM]) begin
      nm_x_q   <= DN'({num_mag[W-1:0], {FRAC_W{1'b0}}});
      nm_d_q   <= qsub(sr7_q, sl7_q);
      nm_neg_q <= num[W-1];
      nm_bl_q  <= bl7_q;
      nm_up_q  <= up7_q;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [W-1:0]        dv_r_q   [DIV_ST];
  logic [DN-1:0]       dv_qt_q  [DIV_ST];
  logic [DN-1:0]       dv_x_q   [DIV_ST];
  logic [W-1:0]        dv_d_q   [DIV_ST];
  logic                dv_neg_q [DIV_ST];
  logic                dv_bl_q  [DIV_ST];
  logic signed [W-1:0] dv_up_q  [DIV_ST];

  for (genvar g = 0; g < DIV_ST; g++) begin : g_dv
    logic [W-1:0]        r_in, d_in, r_nx;
    logic [DN-1:0]       q_in, x_in, q_nx, x_nx;
    logic                neg_in, bl_in;
    logic signed [W-1:0] up_in;

    if (g == 0) begin : g_first
      assign r_in   = '0;
      assign q_in   = '0;
      assign x_in   = nm_x_q;
      assign d_in   = nm_d_q;
      assign neg_in = nm_neg_q;
      assign bl_in  = nm_bl_q;
      assign up_in  = nm_up_q;
    end else begin : g_next
      assign r_in   = dv_r_q[g-1];
      assign q_in   = dv_qt_q[g-1];
      assign x_in   = dv_x_q[g-1];
      assign d_in   = dv_d_q[g-1];
      assign neg_in = dv_neg_q[g-1];
      assign bl_in  = dv_bl_q[g-1];
      assign up_in  = dv_up_q[g-1];
    end

    always_comb begin
      logic [W:0]    rt;
      logic [W-1:0]  r;
      logic [DN-1:0] q;
      logic [DN-1:0] x;
      r = r_in;
      q = q_in;
      x = x_in;
      for (int j = 0; j < DIV_PER; j++) begin
        rt = {r, x[DN-1]};
        x  = x << 1;
        if (rt >= {1'b0, d_in}) begin
          rt = rt - {1'b0, d_in};
          q  = {q[DN-2:0], 1'b1};
        end else begin
          q  = {q[DN-2:0], 1'b0};
        end
        r = rt[W-1:0];
      end
      r_nx = r;
      q_nx = q;
      x_nx = x;
    end

    always_ff @(posedge clk_i) begin
      if (ld[ST_DV+g]) begin
        dv_r_q[g]   <= r_nx;
        dv_qt_q[g]  <= q_nx;
        dv_x_q[g]   <= x_nx;
        dv_d_q[g]   <= d_in;
        dv_neg_q[g] <= neg_in;
        dv_bl_q[g]  <= bl_in;
        dv_up_q[g]  <= up_in;
      end
    end
  end

  // ---------------------------------------------------------------- finish
  logic [DN:0]          qq;
  logic                 qneg;
  logic signed [W-1:0]  quo, res;
  logic [FIELD_W-1:0]   out_q;

  assign qneg = dv_neg_q[DIV_ST-1];
  // negative inexact quotients round toward minus infinity
  assign qq = {1'b0, dv_qt_q[DIV_ST-1]} + (DN+1)'(qneg && (|dv_r_q[DIV_ST-1]));

  always_comb begin
    if (!qneg) begin
      quo = (|qq[DN:W-1]) ? {1'b0, {(W-1){1'b1}}} : qq[W-1:0];
    end else if ((|qq[DN:W]) || (qq[W-1] && (|qq[W-2:0]))) begin
      quo = {1'b1, {(W-1){1'b0}}};
    end else begin
      quo = -qq[W-1:0];
    end
    res = dv_bl_q[DIV_ST-1] ? quo : dv_up_q[DIV_ST-1];
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_OUT]) begin
      out_q <= sat32(res);
    end
  end

  assign m_axis_tdata = out_q;

endmodule

### rtl/hffsw_checker.sv
// Port-level checks for the HLL face flux unit, bound to the top level.
module hffsw_checker
  import hffsw_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [FIELD_W-1:0]      m_axis_tdata,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // an empty output stage means the whole pipeline can advance
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a ready downstream never blocks the input
  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with ready sink");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

  // tvalid on the input side is only watched, the checker never drives it
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(s_axis_tvalid))
    else $error("input valid unknown");

endmodule

bind hll_face_flux_shallow_water_unit hffsw_checker u_hffsw_checker (.*);
